// ===== hw/rtl/escstrip_pkg.sv =====
// escstrip_pkg: shared types, character codes and class functions for the escape stripper
package escstrip_pkg;

  typedef logic [7:0] byte_t;

  // parser state, one-hot
  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_ESC        = 8'b0000_0010,
    ST_ESC_INTER  = 8'b0000_0100,
    ST_CSI_START  = 8'b0000_1000,
    ST_CSI_PRIV2  = 8'b0001_0000,
    ST_CSI_BODY   = 8'b0010_0000,
    ST_OSC_DIGITS = 8'b0100_0000,
    ST_OSC_TEXT   = 8'b1000_0000
  } parse_state_t;

  // character codes
  localparam byte_t CH_BEL      = 8'h07;
  localparam byte_t CH_BS       = 8'h08;
  localparam byte_t CH_HT       = 8'h09;
  localparam byte_t CH_VT       = 8'h0B;
  localparam byte_t CH_FF       = 8'h0C;
  localparam byte_t CH_SO       = 8'h0E;
  localparam byte_t CH_SI       = 8'h0F;
  localparam byte_t CH_ESC      = 8'h1B;
  localparam byte_t CH_SEMI     = 8'h3B;
  localparam byte_t CH_LBRACKET = 8'h5B;
  localparam byte_t CH_RBRACKET = 8'h5D;
  localparam byte_t CH_DEL      = 8'h7F;

  // c locale character classes, upper half belongs to none
  function automatic logic is_digit(input byte_t c);
    is_digit = c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_inter(input byte_t c);
    is_inter = c inside {[8'h20:8'h2F]};
  endfunction

  function automatic logic is_cntrl(input byte_t c);
    is_cntrl = (c inside {[8'h00:8'h1F]}) || (c == CH_DEL);
  endfunction

  function automatic logic is_punct(input byte_t c);
    is_punct = c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
  endfunction

  function automatic logic is_print(input byte_t c);
    is_print = c inside {[8'h20:8'h7E]};
  endfunction

  // csi body: parameters, intermediates and controls keep the sequence open
  function automatic parse_state_t csi_body(input byte_t c);
    if (is_inter(c) || (c == CH_SEMI) || is_digit(c) || is_cntrl(c)) begin
      csi_body = ST_CSI_BODY;
    end else begin
      csi_body = ST_IDLE;
    end
  endfunction

endpackage

// ===== hw/rtl/escstrip_if.sv =====
// escstrip_if: valid/ready channel interfaces for input and result words
interface escstrip_in_if import escstrip_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface escstrip_out_if import escstrip_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  keep;
  logic  out_last;

  modport source (output valid, output out_byte, output keep, output out_last, input ready);
  modport sink   (input valid, input out_byte, input keep, input out_last, output ready);
endinterface

// ===== hw/rtl/ansi_escape_stripper.sv =====
// ansi_escape_stripper: strips selected control bytes and escape sequences from a byte stream
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    data_byte[7:0], last
//  out_ch   out  valid/ready    out_byte[7:0], keep, out_last
//
//  one word per cycle sustained while out_ch is ready; an accepted word passes the input
//  register, where the parser classifies it and updates its state, and then the result register
//  rst_n is synchronous, active low; parser returns to idle and both stages empty
//  a stalled out_ch fills the input register, then in_ch ready drops; no word is lost
module ansi_escape_stripper import escstrip_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  escstrip_in_if.sink    in_ch,
  escstrip_out_if.source out_ch
);

  logic         s1_valid_r;
  byte_t        s1_byte_r;
  logic         s1_last_r;
  logic         out_valid_r;
  byte_t        out_byte_r;
  logic         out_keep_r;
  logic         out_last_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         keep_nxt;
  logic         s2_ready;
  logic         s1_fire;

  // stage handshake
  assign s2_ready    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s2_ready;
  assign in_ch.ready = !s1_valid_r || s2_ready;

  // classify the word in the input register
  always_comb begin
    keep_nxt  = 1'b0;
    state_nxt = ST_IDLE;
    case (state_r)
      ST_IDLE: begin
        if (s1_byte_r inside {CH_BEL, CH_BS, CH_HT, CH_VT, CH_FF, CH_SO, CH_SI}) begin
          state_nxt = ST_IDLE;
        end else if (s1_byte_r == CH_ESC) begin
          state_nxt = ST_ESC;
        end else begin
          keep_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ESC: begin
        if (s1_byte_r == CH_LBRACKET) begin
          state_nxt = ST_CSI_START;
        end else if (s1_byte_r == CH_RBRACKET) begin
          state_nxt = ST_OSC_DIGITS;
        end else if (is_inter(s1_byte_r)) begin
          state_nxt = ST_ESC_INTER;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ESC_INTER: begin
        state_nxt = is_inter(s1_byte_r) ? ST_ESC_INTER : ST_IDLE;
      end
      ST_CSI_START: begin
        if (s1_byte_r inside {8'h40, [8'h5B:8'h60], [8'h7B:8'h7E]}) begin
          state_nxt = ST_IDLE;
        end else if (s1_byte_r inside {[8'h3A:8'h3F]}) begin
          state_nxt = ST_CSI_PRIV2;
        end else begin
          state_nxt = csi_body(s1_byte_r);
        end
      end
      ST_CSI_PRIV2: begin
        if (is_punct(s1_byte_r) && !is_inter(s1_byte_r)) begin
          state_nxt = ST_CSI_BODY;
        end else begin
          state_nxt = csi_body(s1_byte_r);
        end
      end
      ST_CSI_BODY: begin
        state_nxt = csi_body(s1_byte_r);
      end
      ST_OSC_DIGITS: begin
        state_nxt = is_digit(s1_byte_r) ? ST_OSC_DIGITS : ST_OSC_TEXT;
      end
      ST_OSC_TEXT: begin
        state_nxt = is_print(s1_byte_r) ? ST_OSC_TEXT : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last;
    end
  end

  // parser state, end of string returns to idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (s1_fire) begin
      state_r <= s1_last_r ? ST_IDLE : state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_byte_r <= keep_nxt ? s1_byte_r : 8'h00;
      out_keep_r <= keep_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.keep     = out_keep_r;
  assign out_ch.out_last = out_last_r;

`ifndef SYNTHESIS
  // end of string leaves the parser idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> state_r == ST_IDLE)
    else $error("parser not idle after last word");

  // a kept word is only classified from idle
  a_keep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && keep_nxt |-> state_r == ST_IDLE)
    else $error("word kept inside a sequence");

  // a stripped word carries a zero byte
  a_strip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_keep_r |-> out_byte_r == 8'h00)
    else $error("stripped word has nonzero byte");

  // an open sink never stalls the input
  a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output is ready");

  // a word in the input register moves on when the result register frees up
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_valid_r)
    else $error("word lost between stages");
`endif

endmodule

// ===== tb/escstrip_result_check.sv =====
// escstrip_result_check: watches both channels, predicts each result word and compares it
module escstrip_result_check import escstrip_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  escstrip_in_if         in_ch,
  escstrip_out_if        out_ch,
  output int             fail_count,
  output int             outstanding,
  output int             words_in,
  output int             words_out,
  output int             kept_words,
  output int             strings_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    byte_t out_byte;
    logic  keep;
    logic  out_last;
  } strip_result_t;

  parse_state_t  scan_state;
  strip_result_t stripped_q[$];

  // c locale classes, upper half in none
  function automatic logic c_digit(input byte_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic c_inter(input byte_t c);
    return (c >= 8'h20) && (c <= 8'h2F);
  endfunction

  function automatic logic c_cntrl(input byte_t c);
    return (c <= 8'h1F) || (c == CH_DEL);
  endfunction

  function automatic logic c_punct(input byte_t c);
    return ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
           ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
  endfunction

  // parameters, intermediates and controls keep a csi open
  function automatic parse_state_t csi_next(input byte_t c);
    if (c_inter(c) || (c == CH_SEMI) || c_digit(c) || c_cntrl(c)) begin
      return ST_CSI_BODY;
    end
    return ST_IDLE;
  endfunction

  // one byte through the parser, advances scan_state
  function automatic strip_result_t classify_byte(input byte_t c, input logic lst);
    strip_result_t res;
    parse_state_t  nxt;
    res.out_byte = '0;
    res.keep     = 1'b0;
    res.out_last = lst;
    nxt          = ST_IDLE;
    case (scan_state)
      ST_IDLE: begin
        if (c == CH_ESC) begin
          nxt = ST_ESC;
        end else if (!(c == CH_BEL || c == CH_BS || c == CH_HT || c == CH_VT ||
                       c == CH_FF || c == CH_SO || c == CH_SI)) begin
          res.keep     = 1'b1;
          res.out_byte = c;
        end
      end
      ST_ESC: begin
        if (c == CH_LBRACKET) nxt = ST_CSI_START;
        else if (c == CH_RBRACKET) nxt = ST_OSC_DIGITS;
        else if (c_inter(c)) nxt = ST_ESC_INTER;
      end
      ST_ESC_INTER: begin
        if (c_inter(c)) nxt = ST_ESC_INTER;
      end
      ST_CSI_START: begin
        // '@' and the bracket/brace punctuation close an empty csi
        if ((c == 8'h40) || ((c >= 8'h5B) && (c <= 8'h60)) ||
            ((c >= 8'h7B) && (c <= 8'h7E))) begin
          nxt = ST_IDLE;
        end else if ((c >= 8'h3A) && (c <= 8'h3F)) begin
          nxt = ST_CSI_PRIV2;
        end else begin
          nxt = csi_next(c);
        end
      end
      ST_CSI_PRIV2: begin
        if (c_punct(c) && !c_inter(c)) nxt = ST_CSI_BODY;
        else nxt = csi_next(c);
      end
      ST_CSI_BODY: begin
        nxt = csi_next(c);
      end
      ST_OSC_DIGITS: begin
        nxt = c_digit(c) ? ST_OSC_DIGITS : ST_OSC_TEXT;
      end
      ST_OSC_TEXT: begin
        if ((c >= 8'h20) && (c <= 8'h7E)) nxt = ST_OSC_TEXT;
      end
      default: nxt = ST_IDLE;
    endcase
    // end of string abandons any open sequence
    scan_state = lst ? ST_IDLE : nxt;
    return res;
  endfunction

  // predict on every accepted input word, compare on every accepted result word
  always @(posedge clk) begin : monitor
    strip_result_t want;
    if (!rst_n) begin
      scan_state = ST_IDLE;
      stripped_q.delete();
      fail_count   = 0;
      words_in     = 0;
      words_out    = 0;
      kept_words   = 0;
      strings_done = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        stripped_q.push_back(classify_byte(in_ch.data_byte, in_ch.last));
        words_in++;
        if (in_ch.last) strings_done++;
      end
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (out_ch.keep) kept_words++;
        if (stripped_q.size() == 0) begin
          $error("result word 0x%02h with no prediction waiting", out_ch.out_byte);
          fail_count++;
        end else begin
          want = stripped_q.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.keep !== want.keep) begin
            $error("keep: expected %0b, got %0b", want.keep, out_ch.keep);
            fail_count++;
          end
          if (out_ch.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, out_ch.out_last);
            fail_count++;
          end
        end
      end
    end
    outstanding = stripped_q.size();
  end

endmodule

// ===== tb/ansi_escape_stripper_tb.sv =====
// ansi_escape_stripper_tb: clock, reset, byte stream stimulus and result sink with verdict
module ansi_escape_stripper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import escstrip_pkg::*;

  localparam int RANDOM_WORDS     = 1750;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam byte_t DROPPED_CTRLS [7] = '{CH_BEL, CH_BS, CH_HT, CH_VT, CH_FF, CH_SO, CH_SI};

  logic clk;
  logic rst_n;

  escstrip_in_if  in_ch ();
  escstrip_out_if out_ch ();

  int check_fails;
  int check_pending;
  int words_in;
  int words_out;
  int kept_words;
  int strings_done;

  int long_holds_requested = 0;
  int long_holds_done      = 0;
  int burst_left           = 0;
  int words_sent           = 0;
  bit tx_burst             = 1'b0;
  int idle_cycles          = 0;

  ansi_escape_stripper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  escstrip_result_check result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (check_fails),
    .outstanding  (check_pending),
    .words_in     (words_in),
    .words_out    (words_out),
    .kept_words   (kept_words),
    .strings_done (strings_done)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no word moved for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // offer one word after a random gap, or none in a burst, return once accepted
  task automatic send_word(input byte_t b, input logic l);
    int gap;
    if (tx_burst || (burst_left > 0)) gap = 0;
    else gap = $urandom_range(0, 7);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= l;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // one string of mostly well-formed segments, last flag on its final byte
  task automatic send_random_string();
    byte_t line_q[$];
    int    n;
    line_q.delete();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // plain text, upper half included
          repeat ($urandom_range(1, 8)) line_q.push_back(byte_t'($urandom_range(8'h20, 8'hFF)));
        end
        2: begin
          if ($urandom_range(0, 1) == 0) line_q.push_back(DROPPED_CTRLS[$urandom_range(0, 6)]);
          else line_q.push_back(byte_t'($urandom_range(8'h01, 8'h1F)));
        end
        3, 4: begin
          // csi with optional private bytes, body and final
          line_q.push_back(CH_ESC);
          line_q.push_back(CH_LBRACKET);
          if ($urandom_range(0, 2) == 0) begin
            line_q.push_back(byte_t'($urandom_range(8'h3A, 8'h3F)));
            if ($urandom_range(0, 1) == 0) begin
              case ($urandom_range(0, 3))
                0: line_q.push_back(byte_t'($urandom_range(8'h21, 8'h2F)));
                1: line_q.push_back(byte_t'($urandom_range(8'h3A, 8'h40)));
                2: line_q.push_back(byte_t'($urandom_range(8'h5B, 8'h60)));
                default: line_q.push_back(byte_t'($urandom_range(8'h7B, 8'h7E)));
              endcase
            end
          end
          repeat ($urandom_range(0, 5)) begin
            n = $urandom_range(0, 9);
            if (n < 6) line_q.push_back(byte_t'($urandom_range(8'h30, 8'h39)));
            else if (n < 8) line_q.push_back(CH_SEMI);
            else if (n == 8) line_q.push_back(byte_t'($urandom_range(8'h20, 8'h2F)));
            else line_q.push_back(byte_t'($urandom_range(8'h01, 8'h1F)));
          end
          if ($urandom_range(0, 4) == 0) line_q.push_back(byte_t'($urandom_range(8'h80, 8'hFF)));
          else line_q.push_back(byte_t'($urandom_range(8'h40, 8'h7E)));
        end
        5: begin
          // osc: digits, separator, text, terminator
          line_q.push_back(CH_ESC);
          line_q.push_back(CH_RBRACKET);
          repeat ($urandom_range(0, 3)) line_q.push_back(byte_t'($urandom_range(8'h30, 8'h39)));
          if ($urandom_range(0, 2) != 0) line_q.push_back(CH_SEMI);
          else line_q.push_back(byte_t'($urandom_range(8'h01, 8'hFF)));
          repeat ($urandom_range(0, 8)) line_q.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
          case ($urandom_range(0, 3))
            0: line_q.push_back(CH_BEL);
            1: line_q.push_back(CH_ESC);
            2: line_q.push_back(byte_t'($urandom_range(8'h80, 8'hFF)));
            default: line_q.push_back(byte_t'($urandom_range(8'h01, 8'h1F)));
          endcase
        end
        6: begin
          line_q.push_back(CH_ESC);
          repeat ($urandom_range(1, 3)) line_q.push_back(byte_t'($urandom_range(8'h20, 8'h2F)));
          line_q.push_back(byte_t'($urandom_range(8'h30, 8'hFF)));
        end
        7: begin
          line_q.push_back(CH_ESC);
          line_q.push_back(byte_t'($urandom_range(8'h01, 8'hFF)));
        end
        default: begin
          repeat ($urandom_range(1, 6)) line_q.push_back(byte_t'($urandom_range(8'h01, 8'hFF)));
        end
      endcase
    end
    // rare early last cuts a sequence short
    foreach (line_q[i]) begin
      send_word(line_q[i], (i == line_q.size() - 1) || ($urandom_range(0, 39) == 0));
    end
  endtask

  // result sink with random stalls, bursts and requested long holds
  initial begin : result_sink
    int stall;
    bit rx_burst;
    rx_burst     = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      if (long_holds_done != long_holds_requested) begin
        stall = LONG_HOLD_CYCLES;
        long_holds_done++;
      end else if (rx_burst) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // reset, directed bytes, random strings, drain and verdict
  initial begin : stimulus
    logic [8:0] directed_words[$];
    int         pressure_step;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last      = 1'b0;
    pressure_step   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // {last, byte}: range ends, each dropped control, csi with two private bytes,
    // osc ended by bel, esc with intermediate, csi cut off by last
    directed_words = '{
      {1'b0, 8'h41}, {1'b0, 8'hFF}, {1'b0, 8'h01},
      {1'b0, CH_BEL}, {1'b0, CH_BS}, {1'b0, CH_HT}, {1'b0, CH_VT},
      {1'b0, CH_FF}, {1'b0, CH_SO}, {1'b0, CH_SI},
      {1'b0, CH_ESC}, {1'b0, CH_LBRACKET}, {1'b0, 8'h3F}, {1'b0, 8'h3D},
      {1'b0, 8'h32}, {1'b0, CH_SEMI}, {1'b0, 8'h6D},
      {1'b0, CH_ESC}, {1'b0, CH_RBRACKET}, {1'b0, 8'h32}, {1'b0, 8'h78}, {1'b0, CH_BEL},
      {1'b0, CH_ESC}, {1'b0, 8'h28}, {1'b0, 8'h42},
      {1'b0, CH_ESC}, {1'b1, CH_LBRACKET}, {1'b1, 8'h5A}
    };
    foreach (directed_words[i]) send_word(directed_words[i][7:0], directed_words[i][8]);

    while (words_sent < directed_words.size() + RANDOM_WORDS) begin
      if ((pressure_step < 3) && (words_sent >= 450 * (pressure_step + 1))) begin
        if (pressure_step == 1) begin
          // sender pauses until every predicted word is out
          @(negedge clk);
          in_ch.valid <= 1'b0;
          while (check_pending != 0) @(negedge clk);
        end else begin
          // sink holds off while the sender streams back to back
          long_holds_requested++;
          burst_left = 60;
        end
        pressure_step++;
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      send_random_string();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (check_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Covered %0d bytes in %0d strings: %0d passed through, %0d stripped.",
             words_in, strings_done, kept_words, words_out - kept_words);
    $display("Sink held off %0d times for %0d cycles; sender paused once for a full drain.",
             long_holds_done, LONG_HOLD_CYCLES);
    if (check_pending != 0) begin
      $error("%0d predicted words never came out", check_pending);
    end
    if ((check_fails == 0) && (check_pending == 0)) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/escstrip_pkg.sv
hw/rtl/escstrip_if.sv
hw/rtl/ansi_escape_stripper.sv
tb/escstrip_result_check.sv
tb/ansi_escape_stripper_tb.sv
